// ===== hdl/spff_pkg.sv =====
package spff_pkg;

  localparam int WORD_W    = 24;
  localparam int WIDTH_W   = 16;
  localparam int CHAN_W    = 4;
  localparam int SENSOR_W  = 2;
  localparam int STATION_W = 5;
  localparam int DELTA_W   = 32;
  localparam int POLY_BIT  = 7;

  localparam logic [WORD_W-1:0] INVALID_OFFSET = 24'hffffff;

  typedef struct packed {
    logic                vld;
    logic [SENSOR_W-1:0] sensor;
    logic [WIDTH_W-1:0]  width;
    logic [CHAN_W-1:0]   chan;
    logic                slow;
    logic [WORD_W-1:0]   beam;
    logic [WORD_W-1:0]   stamp;
  } frame_t;

  typedef struct packed {
    logic              emit;
    logic [WORD_W-1:0] earlier_beam;
  } lookup_t;

endpackage

// ===== hdl/spff_in_reg.sv =====
module spff_in_reg
  import spff_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [WORD_W-1:0] head_word,
  input  logic [WORD_W-1:0] offset_word,
  input  logic [WORD_W-1:0] beam_value,
  input  logic [WORD_W-1:0] time_stamp,
  output frame_t            frame
);

  logic              vld_r;
  logic [WORD_W-1:0] first_r;
  logic [WORD_W-1:0] offset_r;
  logic [WORD_W-1:0] beam_r;
  logic [WORD_W-1:0] stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      first_r  <= head_word;
      offset_r <= offset_word;
      beam_r   <= beam_value;
      stamp_r  <= time_stamp;
    end
  end

  // drop invalid offset and poly-flagged frames
  always_comb begin
    frame.vld    = vld_r && (offset_r != INVALID_OFFSET) && !first_r[POLY_BIT];
    frame.sensor = first_r[1:0];
    frame.width  = first_r[23:8];
    frame.chan   = first_r[6:3];
    frame.slow   = first_r[2];
    frame.beam   = beam_r;
    frame.stamp  = stamp_r;
  end

endmodule

// ===== hdl/spff_table.sv =====
module spff_table
  import spff_pkg::*;
#(
  parameter int CHANNELS = 16
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  frame_t             frame,
  input  logic [DELTA_W-1:0] max_delta,
  output lookup_t            lookup
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [WIDTH_W-1:0] width_r [CHANNELS];
  logic [WORD_W-1:0]  time_r  [CHANNELS];
  logic [WORD_W-1:0]  beam_r  [CHANNELS];

  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [WIDTH_W-1:0] old_width;
  logic [WORD_W-1:0]  old_time;
  logic [DELTA_W-1:0] diff;
  logic               narrower;
  logic               wr_en;

  assign in_range  = {1'b0, frame.chan} < (CHAN_W+1)'(CHANNELS);
  assign idx       = frame.chan[IDX_W-1:0];
  assign old_width = width_r[idx];
  assign old_time  = time_r[idx];
  // 32-bit wrapped difference, stored minus new
  assign diff      = DELTA_W'(old_time) - DELTA_W'(frame.stamp);
  assign narrower  = old_width > frame.width;

  always_comb begin
    lookup.emit         = frame.vld && in_range && narrower && (diff > max_delta);
    lookup.earlier_beam = beam_r[idx];
    wr_en               = frame.vld && in_range && (!narrower || (diff > max_delta));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        width_r[i] <= '0;
        time_r[i]  <= '0;
        beam_r[i]  <= '0;
      end
    end else if (wr_en) begin
      width_r[idx] <= frame.width;
      time_r[idx]  <= frame.stamp;
      beam_r[idx]  <= frame.beam;
    end
  end

endmodule

// ===== hdl/sweep_pulse_frame_filter.sv =====
// a word is captured in the input register, looked up in the channel table and
// registered into the result outputs, where the receiver takes it
// throughput: one word per cycle, busy never rises
// the channel table is read and rewritten in the same cycle, so back-to-back
// words on the same channel see each other's updates
// synchronous active-low reset clears the table, the gap limit and strobes;
// the receiver cannot stall and out_valid lasts exactly one cycle per result
module sweep_pulse_frame_filter
  import spff_pkg::*;
#(
  parameter int CHANNELS = 16
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    in_head_word,
  input  logic [WORD_W-1:0]    in_offset_word,
  input  logic [WORD_W-1:0]    in_beam_value,
  input  logic [WORD_W-1:0]    in_time_stamp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [DELTA_W-1:0]   cfg_gap_limit,
  output logic                 out_valid,
  output logic [SENSOR_W-1:0]  out_sensor_id,
  output logic [WORD_W-1:0]    out_beam_out,
  output logic [WORD_W-1:0]    out_time_out,
  output logic [WORD_W-1:0]    out_earlier_beam,
  output logic [STATION_W-1:0] out_base_station,
  output logic                 out_station_subchannel
);

  frame_t             frame;
  lookup_t            lookup;
  logic [DELTA_W-1:0] max_delta_r;
  logic               out_valid_r;
  logic [SENSOR_W-1:0]  sensor_r;
  logic [WORD_W-1:0]    beam_out_r;
  logic [WORD_W-1:0]    time_out_r;
  logic [WORD_W-1:0]    earlier_r;
  logic [STATION_W-1:0] station_r;
  logic                 sub_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delta_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_delta_r <= cfg_gap_limit;
    end
  end

  spff_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (start && !busy),
    .head_word   (in_head_word),
    .offset_word (in_offset_word),
    .beam_value  (in_beam_value),
    .time_stamp  (in_time_stamp),
    .frame       (frame)
  );

  spff_table #(
    .CHANNELS (CHANNELS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .max_delta (max_delta_r),
    .lookup    (lookup)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= lookup.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup.emit) begin
      sensor_r   <= frame.sensor;
      beam_out_r <= frame.beam;
      time_out_r <= frame.stamp;
      earlier_r  <= lookup.earlier_beam;
      station_r  <= STATION_W'(frame.chan) + STATION_W'(1);
      sub_r      <= frame.slow;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_sensor_id          = sensor_r;
  assign out_beam_out           = beam_out_r;
  assign out_time_out           = time_out_r;
  assign out_earlier_beam       = earlier_r;
  assign out_base_station       = station_r;
  assign out_station_subchannel = sub_r;

endmodule

// ===== dv/sweep_pulse_frame_filter_test.sv =====
module sweep_pulse_frame_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spff_pkg::*;

  localparam int CHANNELS       = 16;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WORDS_PER_PASS = 140;
  localparam int CYCLE_LIMIT    = 300000;

  typedef struct packed {
    logic [SENSOR_W-1:0]  sensor;
    logic [WORD_W-1:0]    beam;
    logic [WORD_W-1:0]    stamp;
    logic [WORD_W-1:0]    earlier;
    logic [STATION_W-1:0] station;
    logic                 slow;
  } sweep_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_GIVEN
  } row_kind_e;

  typedef struct packed {
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] beam;
    logic [WORD_W-1:0] stamp;
    row_kind_e         kind;
    sweep_t            given;
  } stim_row_t;

  // head word: width, poly flag, channel, slow bit, sensor
  localparam stim_row_t DIRECTED [15] = '{
    // invalid offset, poly flag, both
    '{{16'h1234, 1'b0, 4'd2, 1'b0, 2'd0}, 24'hffffff, 24'h111111, 24'h000100, ROW_SILENT, '0},
    '{{16'h1234, 1'b1, 4'd2, 1'b0, 2'd0}, 24'h000000, 24'h222222, 24'h000100, ROW_SILENT, '0},
    '{{16'hffff, 1'b1, 4'd15, 1'b1, 2'd3}, 24'hffffff, 24'h333333, 24'hffffff, ROW_SILENT, '0},
    // fresh table entry
    '{{16'hffff, 1'b0, 4'd0, 1'b0, 2'd1}, 24'h000000, 24'haaaaaa, 24'h000010, ROW_SILENT, '0},
    '{{16'h0000, 1'b0, 4'd0, 1'b0, 2'd2}, 24'hfffffe, 24'h555555, 24'h000005, ROW_GIVEN,
      '{2'd2, 24'h555555, 24'h000005, 24'haaaaaa, 5'd1, 1'b0}},
    // equal width
    '{{16'h0000, 1'b0, 4'd0, 1'b1, 2'd0}, 24'h000001, 24'h0000ff, 24'h000001, ROW_SILENT, '0},
    '{{16'h8000, 1'b0, 4'd15, 1'b1, 2'd3}, 24'h000000, 24'hffffff, 24'hffffff, ROW_SILENT, '0},
    // zero time difference
    '{{16'h7fff, 1'b0, 4'd15, 1'b1, 2'd3}, 24'h7fffff, 24'h000000, 24'hffffff, ROW_SILENT, '0},
    '{{16'h7fff, 1'b0, 4'd15, 1'b1, 2'd3}, 24'h800000, 24'h000000, 24'h000000, ROW_GIVEN,
      '{2'd3, 24'h000000, 24'h000000, 24'hffffff, 5'd16, 1'b1}},
    // later timestamp wraps to a large difference
    '{{16'h0100, 1'b0, 4'd3, 1'b0, 2'd1}, 24'h000000, 24'h123456, 24'h000001, ROW_SILENT, '0},
    '{{16'h00ff, 1'b0, 4'd3, 1'b1, 2'd0}, 24'h000000, 24'h654321, 24'h000002, ROW_GIVEN,
      '{2'd0, 24'h654321, 24'h000002, 24'h123456, 5'd4, 1'b1}},
    // same channel back to back
    '{{16'hffff, 1'b0, 4'd7, 1'b0, 2'd2}, 24'h0f0f0f, 24'h0f0f0f, 24'h800000, ROW_PREDICT, '0},
    '{{16'hfffe, 1'b0, 4'd7, 1'b1, 2'd1}, 24'hf0f0f0, 24'hc3c3c3, 24'h7fffff, ROW_PREDICT, '0},
    '{{16'h0001, 1'b0, 4'd7, 1'b0, 2'd3}, 24'h3c3c3c, 24'h5a5a5a, 24'h000000, ROW_PREDICT, '0},
    '{{16'h0000, 1'b0, 4'd7, 1'b1, 2'd2}, 24'ha5a5a5, 24'hf0f0f0, 24'h000000, ROW_PREDICT, '0}
  };

  localparam logic [DELTA_W-1:0] PASS_LIMITS [7] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_0100, 32'h00ff_ffff,
    32'h7fff_ffff, 32'h0000_0003, 32'h0000_0000
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [WORD_W-1:0]    in_head_word = '0;
  logic [WORD_W-1:0]    in_offset_word = '0;
  logic [WORD_W-1:0]    in_beam_value = '0;
  logic [WORD_W-1:0]    in_time_stamp = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [DELTA_W-1:0]   cfg_gap_limit = '0;
  logic                 out_valid;
  logic [SENSOR_W-1:0]  out_sensor_id;
  logic [WORD_W-1:0]    out_beam_out;
  logic [WORD_W-1:0]    out_time_out;
  logic [WORD_W-1:0]    out_earlier_beam;
  logic [STATION_W-1:0] out_base_station;
  logic                 out_station_subchannel;

  logic [WIDTH_W-1:0] chan_width [CHANNELS];
  logic [WORD_W-1:0]  chan_time [CHANNELS];
  logic [WORD_W-1:0]  chan_beam [CHANNELS];
  logic [DELTA_W-1:0] delta_limit;

  sweep_t pending_sweeps [$];
  int     mismatches = 0;
  int     cycle_count = 0;

  sweep_pulse_frame_filter #(.CHANNELS(CHANNELS)) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_head_word           (in_head_word),
    .in_offset_word         (in_offset_word),
    .in_beam_value          (in_beam_value),
    .in_time_stamp          (in_time_stamp),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_gap_limit          (cfg_gap_limit),
    .out_valid              (out_valid),
    .out_sensor_id          (out_sensor_id),
    .out_beam_out           (out_beam_out),
    .out_time_out           (out_time_out),
    .out_earlier_beam       (out_earlier_beam),
    .out_base_station       (out_base_station),
    .out_station_subchannel (out_station_subchannel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // returns 1 when a sweep is reported; live is 0 for dropped frames
  function automatic bit predict_sweep(input logic [WORD_W-1:0] fw, off, beam, stamp,
                                       output sweep_t s, output bit live);
    logic [WIDTH_W-1:0] w;
    logic [4:0]         ident;
    logic [4:0]         ch;
    logic [DELTA_W-1:0] gap;
    bit                 hit;
    s = '0;
    live = 1'b0;
    hit = 1'b0;
    if (off == INVALID_OFFSET || fw[POLY_BIT]) return 1'b0;
    w = fw[8 +: WIDTH_W];
    ident = fw[6:2];
    ch = ident >> 1;
    if (ch >= CHANNELS) return 1'b0;
    live = 1'b1;
    if (chan_width[ch] > w) begin
      gap = DELTA_W'(chan_time[ch]) - DELTA_W'(stamp);
      if (gap <= delta_limit) return 1'b0;
      s.sensor = fw[SENSOR_W-1:0];
      s.beam = beam;
      s.stamp = stamp;
      s.earlier = chan_beam[ch];
      s.station = STATION_W'(ch) + 1'b1;
      s.slow = ident[0];
      hit = 1'b1;
    end
    chan_width[ch] = w;
    chan_time[ch] = stamp;
    chan_beam[ch] = beam;
    return hit;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] fw, off, beam, stamp);
    start <= 1'b1;
    in_head_word <= fw;
    in_offset_word <= off;
    in_beam_value <= beam;
    in_time_stamp <= stamp;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    in_head_word <= WORD_W'($urandom);
    in_offset_word <= WORD_W'($urandom);
    in_beam_value <= WORD_W'($urandom);
    in_time_stamp <= WORD_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_sweeps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_delta_limit(input logic [DELTA_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_gap_limit <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    delta_limit = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic make_frame(output logic [WORD_W-1:0] fw, off, beam, stamp);
    int                 pick;
    logic [CHAN_W-1:0]  ch;
    logic [WIDTH_W-1:0] w;
    logic [DELTA_W-1:0] back;
    pick = $urandom_range(0, 99);
    ch = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 3)) : CHAN_W'($urandom);
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = chan_width[ch];
      3, 4: w = chan_width[ch] - WIDTH_W'($urandom_range(1, 4));
      default: w = WIDTH_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: back = $urandom;
      1: back = delta_limit;
      2: back = delta_limit + 1;
      default: back = $urandom_range(0, 3);
    endcase
    stamp = WORD_W'(DELTA_W'(chan_time[ch]) - back);
    fw = {w, 1'b0, ch, 1'($urandom), SENSOR_W'($urandom)};
    off = WORD_W'($urandom);
    beam = WORD_W'($urandom);
    // noise: dropped and arbitrary frames
    if (pick < 6) off = INVALID_OFFSET;
    else if (pick < 12) fw[POLY_BIT] = 1'b1;
    else if (pick < 15) fw = WORD_W'($urandom);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sweep_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_sweeps.size() == 0) begin
        $error("result word with none expected: beam %0h time %0h", out_beam_out,
               out_time_out);
        mismatches++;
      end else begin
        want = pending_sweeps.pop_front();
        check_field("sensor_id", 32'(want.sensor), 32'(out_sensor_id));
        check_field("beam_out", 32'(want.beam), 32'(out_beam_out));
        check_field("time_out", 32'(want.stamp), 32'(out_time_out));
        check_field("earlier_beam", 32'(want.earlier), 32'(out_earlier_beam));
        check_field("base_station", 32'(want.station), 32'(out_base_station));
        check_field("station_subchannel", 32'(want.slow), 32'(out_station_subchannel));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [WORD_W-1:0] fw, off, beam, stamp;
    sweep_t            s;
    bit                hit;
    bit                live;
    int                live_count;
    int                burst;
    logic [DELTA_W-1:0] lim;

    foreach (chan_width[i]) begin
      chan_width[i] = '0;
      chan_time[i] = '0;
      chan_beam[i] = '0;
    end
    delta_limit = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].first, DIRECTED[i].offset, DIRECTED[i].beam, DIRECTED[i].stamp);
      hit = predict_sweep(DIRECTED[i].first, DIRECTED[i].offset, DIRECTED[i].beam,
                          DIRECTED[i].stamp, s, live);
      case (DIRECTED[i].kind)
        ROW_PREDICT: begin
          if (hit) pending_sweeps.push_back(s);
        end
        ROW_GIVEN: begin
          pending_sweeps.push_back(DIRECTED[i].given);
        end
        default: begin
        end
      endcase
    end

    foreach (PASS_LIMITS[p]) begin
      lim = (p == 5) ? DELTA_W'($urandom) : PASS_LIMITS[p];
      write_delta_limit(lim);
      live_count = 0;
      while (live_count < WORDS_PER_PASS) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          make_frame(fw, off, beam, stamp);
          send_word(fw, off, beam, stamp);
          if (predict_sweep(fw, off, beam, stamp, s, live)) pending_sweeps.push_back(s);
          if (live) live_count++;
        end
        // pass 2 runs without gaps
        if (p != 2 && $urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
